// File: rtl/ogff_pkg.sv
// ----------------------------------------------------------------------------
// ogff_pkg
// Shared types and codes of the occupancy grid frontier finder.
// ----------------------------------------------------------------------------
package ogff_pkg;

  localparam int CoordW = 5;
  localparam int CellW  = 2;

  typedef logic [1:0]               opcode_t;
  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [CellW-1:0]         cell_t;

  localparam opcode_t OP_WRITE = 2'd0;
  localparam opcode_t OP_MARK  = 2'd1;
  localparam opcode_t OP_SCAN  = 2'd2;
  localparam opcode_t OP_NONE  = 2'd3;

  localparam cell_t CELL_FREE     = 2'd0;
  localparam cell_t CELL_UNKNOWN  = 2'd1;
  localparam cell_t CELL_OCCUPIED = 2'd2;

  // rows reported by a scan lie in the coordinate range
  localparam int COORD_LO = -16;
  localparam int COORD_HI = 15;

endpackage

// File: rtl/ogff_ifs.sv
// ----------------------------------------------------------------------------
// ogff_ifs
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface ogff_in_if;
  logic               valid;
  logic               ready;
  ogff_pkg::opcode_t  opcode;
  ogff_pkg::coord_t   x_coord;
  ogff_pkg::coord_t   y_coord;
  ogff_pkg::cell_t    cell_value;

  modport source (output valid, output opcode, output x_coord, output y_coord,
                  output cell_value, input ready);
  modport sink   (input valid, input opcode, input x_coord, input y_coord,
                  input cell_value, output ready);
endinterface

interface ogff_out_if;
  logic               valid;
  logic               ready;
  ogff_pkg::coord_t   found_x;
  ogff_pkg::coord_t   found_y;
  logic               frontier_found;
  logic               write_dropped;
  logic               last_result;

  modport source (output valid, output found_x, output found_y, output frontier_found,
                  output write_dropped, output last_result, input ready);
  modport sink   (input valid, input found_x, input found_y, input frontier_found,
                  input write_dropped, input last_result, output ready);
endinterface

// File: rtl/occupancy_grid_frontier_finder.sv
// ----------------------------------------------------------------------------
// occupancy_grid_frontier_finder
// Square occupancy grid held one column per memory word, with cell writes,
// 3x3 free marking and column frontier scans.
// ----------------------------------------------------------------------------
// The grid is stored as GRID_SIDE words of GRID_SIDE cells, one word per
// column, in a single-port-write, single-port-read memory with a registered
// read. After reset a clearing pass sets every cell to unknown, column by
// column; no item is accepted until it ends. Items are handled one at a
// time, each column passing through a read state and a write-back state: a
// cell write touches one column, a 3x3 mark three, and a scan reads three
// columns, builds a frontier vector and walks the candidate rows (at most 32
// at GRID_SIDE 32), emitting one result per frontier row or one empty result
// if none. A held output result does not block accepting the next item.
module occupancy_grid_frontier_finder #(
  parameter int GRID_SIDE = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  ogff_in_if.sink       in_ch,
  ogff_out_if.source    out_ch
);

  localparam int AW   = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int OW   = ((AW > 6) ? AW : 6) + 2;
  localparam int WW   = GRID_SIDE * ogff_pkg::CellW;
  localparam int HALF_I = GRID_SIDE / 2;
  localparam int JLO_I  = (HALF_I + ogff_pkg::COORD_LO > 0) ? HALF_I + ogff_pkg::COORD_LO : 0;
  localparam int JHI_I  = (HALF_I + ogff_pkg::COORD_HI < GRID_SIDE - 1) ?
                          HALF_I + ogff_pkg::COORD_HI : GRID_SIDE - 1;

  localparam logic signed [OW-1:0] HALF   = OW'(HALF_I);
  localparam logic signed [OW-1:0] SIDE_S = OW'(GRID_SIDE);
  localparam logic signed [OW-1:0] ONE_S  = OW'(1);
  localparam logic [AW-1:0]        LAST_COL = AW'(GRID_SIDE - 1);
  localparam logic [AW-1:0]        JLO      = AW'(JLO_I);
  localparam logic [AW-1:0]        JHI      = AW'(JHI_I);
  localparam logic [WW-1:0]        ALL_UNK  = {GRID_SIDE{ogff_pkg::CELL_UNKNOWN}};

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_WB    = 3'd3;
  localparam logic [2:0] ST_FRONT = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;
  localparam logic [2:0] ST_RESP  = 3'd6;

  function automatic logic on_grid(input logic signed [OW-1:0] v);
    on_grid = !v[OW-1] && (v < SIDE_S);
  endfunction

  // grid memory
  logic [WW-1:0] grid_mem [0:GRID_SIDE-1];
  logic [WW-1:0] rd_q_r;
  logic          mem_re;
  logic          mem_we;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q_r <= grid_mem[mem_raddr];
    end
  end

  // control and payload registers
  logic [2:0]                 state_r, state_nxt;
  logic [AW-1:0]              clr_r, clr_nxt;
  ogff_pkg::opcode_t          op_r, op_nxt;
  ogff_pkg::coord_t           x_r, x_nxt;
  logic signed [OW-1:0]       yo_r, yo_nxt;
  ogff_pkg::cell_t            val_r, val_nxt;
  logic signed [OW-1:0]       col_r, col_nxt;
  logic signed [OW-1:0]       col_end_r, col_end_nxt;
  logic                       dropped_r, dropped_nxt;
  logic [WW-1:0]              left_r, left_nxt;
  logic [WW-1:0]              mid_r, mid_nxt;
  logic [WW-1:0]              right_r, right_nxt;
  logic [GRID_SIDE-1:0]       fr_r, fr_nxt;
  logic [AW-1:0]              j_r, j_nxt;

  logic                       out_valid_r;
  ogff_pkg::coord_t           out_fx_r, out_fy_r;
  logic                       out_found_r, out_drop_r, out_last_r;

  // input decode
  logic signed [OW-1:0] in_xo, in_yo;
  assign in_xo = OW'(in_ch.x_coord) + HALF;
  assign in_yo = OW'(in_ch.y_coord) + HALF;

  logic in_acc;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // column read-modify-write
  logic [WW-1:0]        col_word;
  logic [WW-1:0]        mod_word;
  logic signed [OW-1:0] y_first, y_last;
  ogff_pkg::cell_t      new_cell;

  assign col_word = on_grid(col_r) ? rd_q_r : ALL_UNK;
  assign y_first  = (op_r == ogff_pkg::OP_WRITE) ? yo_r : yo_r - ONE_S;
  assign y_last   = (op_r == ogff_pkg::OP_WRITE) ? yo_r : yo_r + ONE_S;
  assign new_cell = (op_r == ogff_pkg::OP_WRITE) ? val_r : ogff_pkg::CELL_FREE;

  always_comb begin
    logic signed [OW-1:0] jj;
    mod_word = col_word;
    for (int j = 0; j < GRID_SIDE; j++) begin
      jj = OW'(j);
      if (jj >= y_first && jj <= y_last) begin
        mod_word[j*ogff_pkg::CellW +: ogff_pkg::CellW] = new_cell;
      end
    end
  end

  // frontier vector over the three captured columns
  logic [GRID_SIDE+1:0] unk_l, unk_m, unk_r;
  logic [GRID_SIDE-1:0] fr_comb;

  always_comb begin
    unk_l = '1;
    unk_m = '1;
    unk_r = '1;
    for (int j = 0; j < GRID_SIDE; j++) begin
      unk_l[j+1] = (left_r[j*ogff_pkg::CellW +: ogff_pkg::CellW] == ogff_pkg::CELL_UNKNOWN);
      unk_m[j+1] = (mid_r[j*ogff_pkg::CellW +: ogff_pkg::CellW] == ogff_pkg::CELL_UNKNOWN);
      unk_r[j+1] = (right_r[j*ogff_pkg::CellW +: ogff_pkg::CellW] == ogff_pkg::CELL_UNKNOWN);
    end
    for (int j = 0; j < GRID_SIDE; j++) begin
      fr_comb[j] = (j >= JLO_I) && (j <= JHI_I) &&
                   (mid_r[j*ogff_pkg::CellW +: ogff_pkg::CellW] == ogff_pkg::CELL_FREE) &&
                   (unk_l[j] || unk_l[j+1] || unk_l[j+2] ||
                    unk_m[j] || unk_m[j+2] ||
                    unk_r[j] || unk_r[j+1] || unk_r[j+2]);
    end
  end

  // output register
  logic             out_free;
  logic             ld;
  ogff_pkg::coord_t ld_fx, ld_fy;
  logic             ld_found, ld_drop, ld_last;
  logic signed [OW-1:0] row_y;

  assign out_free = !out_valid_r || out_ch.ready;
  assign row_y    = OW'(j_r) - HALF;

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    op_nxt      = op_r;
    x_nxt       = x_r;
    yo_nxt      = yo_r;
    val_nxt     = val_r;
    col_nxt     = col_r;
    col_end_nxt = col_end_r;
    dropped_nxt = dropped_r;
    left_nxt    = left_r;
    mid_nxt     = mid_r;
    right_nxt   = right_r;
    fr_nxt      = fr_r;
    j_nxt       = j_r;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_raddr   = col_r[AW-1:0];
    mem_waddr   = col_r[AW-1:0];
    mem_wdata   = mod_word;
    ld          = 1'b0;
    ld_fx       = '0;
    ld_fy       = '0;
    ld_found    = 1'b0;
    ld_drop     = dropped_r;
    ld_last     = 1'b1;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = ALL_UNK;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_COL) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt      = in_ch.opcode;
          x_nxt       = in_ch.x_coord;
          yo_nxt      = in_yo;
          val_nxt     = (in_ch.cell_value > ogff_pkg::CELL_OCCUPIED) ?
                        ogff_pkg::CELL_OCCUPIED : in_ch.cell_value;
          dropped_nxt = 1'b0;
          unique case (in_ch.opcode)
            ogff_pkg::OP_WRITE: begin
              col_nxt     = in_xo;
              col_end_nxt = in_xo;
              if (on_grid(in_xo) && on_grid(in_yo)) begin
                state_nxt = ST_RD;
              end else begin
                dropped_nxt = 1'b1;
                state_nxt   = ST_RESP;
              end
            end
            ogff_pkg::OP_MARK: begin
              col_nxt     = in_xo - ONE_S;
              col_end_nxt = in_xo + ONE_S;
              dropped_nxt = !(on_grid(in_xo - ONE_S) && on_grid(in_xo + ONE_S) &&
                              on_grid(in_yo - ONE_S) && on_grid(in_yo + ONE_S));
              state_nxt   = ST_RD;
            end
            ogff_pkg::OP_SCAN: begin
              col_nxt     = in_xo - ONE_S;
              col_end_nxt = in_xo + ONE_S;
              state_nxt   = on_grid(in_xo) ? ST_RD : ST_RESP;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_RD: begin
        mem_re    = on_grid(col_r);
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (op_r == ogff_pkg::OP_SCAN) begin
          left_nxt  = mid_r;
          mid_nxt   = right_r;
          right_nxt = col_word;
        end else begin
          mem_we = on_grid(col_r);
        end
        if (col_r == col_end_r) begin
          state_nxt = (op_r == ogff_pkg::OP_SCAN) ? ST_FRONT : ST_RESP;
        end else begin
          col_nxt   = col_r + ONE_S;
          state_nxt = ST_RD;
        end
      end
      ST_FRONT: begin
        fr_nxt    = fr_comb;
        j_nxt     = JLO;
        state_nxt = (fr_comb == '0) ? ST_RESP : ST_EMIT;
      end
      ST_EMIT: begin
        if (fr_r[j_r]) begin
          if (out_free) begin
            fr_nxt[j_r] = 1'b0;
            ld          = 1'b1;
            ld_fx       = x_r;
            ld_fy       = row_y[ogff_pkg::CoordW-1:0];
            ld_found    = 1'b1;
            ld_drop     = 1'b0;
            ld_last     = (fr_nxt == '0);
            j_nxt       = (j_r == JHI) ? j_r : j_r + AW'(1);
            if (fr_nxt == '0) begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          j_nxt = (j_r == JHI) ? j_r : j_r + AW'(1);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          ld        = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    x_r       <= x_nxt;
    yo_r      <= yo_nxt;
    val_r     <= val_nxt;
    col_r     <= col_nxt;
    col_end_r <= col_end_nxt;
    dropped_r <= dropped_nxt;
    left_r    <= left_nxt;
    mid_r     <= mid_nxt;
    right_r   <= right_nxt;
    fr_r      <= fr_nxt;
    j_r       <= j_nxt;
    if (ld) begin
      out_fx_r    <= ld_fx;
      out_fy_r    <= ld_fy;
      out_found_r <= ld_found;
      out_drop_r  <= ld_drop;
      out_last_r  <= ld_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.found_x        = out_fx_r;
  assign out_ch.found_y        = out_fy_r;
  assign out_ch.frontier_found = out_found_r;
  assign out_ch.write_dropped  = out_drop_r;
  assign out_ch.last_result    = out_last_r;

endmodule

// File: tb/sv/occupancy_grid_frontier_finder_tb.sv
// ----------------------------------------------------------------------------
// occupancy_grid_frontier_finder_tb
// Self-checking bench for the occupancy grid frontier finder. A queue of
// directed and random requests feeds a clocked driver. An in-bench grid
// model predicts the results of every accepted item. A clocked monitor
// checks each result against the oldest prediction. Both sides stall at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module occupancy_grid_frontier_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_SIDE  = 32;
  localparam int GRID_LO    = -(GRID_SIDE / 2);
  localparam int GRID_HI    = GRID_SIDE - 1 - (GRID_SIDE / 2);
  localparam int RAND_ITEMS = 425;
  localparam int HOLD_AT    = 260;
  localparam int HOLD_LEN   = 300;
  localparam int TAIL_CYC   = 100;

  typedef struct packed {
    ogff_pkg::opcode_t op;
    ogff_pkg::coord_t  x;
    ogff_pkg::coord_t  y;
    ogff_pkg::cell_t   val;
  } grid_req_t;

  typedef struct packed {
    ogff_pkg::coord_t fx;
    ogff_pkg::coord_t fy;
    logic             found;
    logic             dropped;
    logic             last;
  } grid_result_t;

  logic clk;
  logic rst_n;

  ogff_in_if  in_ch ();
  ogff_out_if out_ch ();

  occupancy_grid_frontier_finder #(.GRID_SIDE(GRID_SIDE)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  grid_req_t       pending_reqs [$];
  grid_result_t    due_results  [$];
  ogff_pkg::cell_t grid_model   [GRID_SIDE*GRID_SIDE];
  grid_req_t       held_req;
  int              accepted;
  int              results_seen;
  int              fail_cnt;
  int              hold_left;
  bit              hold_done;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------- grid model
  function automatic bit on_grid(int x, int y);
    return x >= GRID_LO && x <= GRID_HI && y >= GRID_LO && y <= GRID_HI;
  endfunction

  function automatic int cell_idx(int x, int y);
    return (x - GRID_LO) * GRID_SIDE + (y - GRID_LO);
  endfunction

  function automatic bit is_frontier(int x, int y);
    ogff_pkg::cell_t c;
    if (!on_grid(x, y) || grid_model[cell_idx(x, y)] != ogff_pkg::CELL_FREE) return 1'b0;
    for (int dx = -1; dx <= 1; dx++) begin
      for (int dy = -1; dy <= 1; dy++) begin
        if (dx != 0 || dy != 0) begin
          c = on_grid(x + dx, y + dy) ? grid_model[cell_idx(x + dx, y + dy)]
                                      : ogff_pkg::CELL_UNKNOWN;
          if (c == ogff_pkg::CELL_UNKNOWN) return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic grid_result_t make_result(int fx, int fy, logic found,
                                               logic dropped, logic last);
    grid_result_t r;
    r.fx      = ogff_pkg::coord_t'(fx);
    r.fy      = ogff_pkg::coord_t'(fy);
    r.found   = found;
    r.dropped = dropped;
    r.last    = last;
    return r;
  endfunction

  function automatic void queue_result(grid_result_t r);
    due_results = {due_results, r};
  endfunction

  function automatic void apply_request(grid_req_t r);
    int              x;
    int              y;
    int              lo;
    int              hi;
    int              n;
    logic            dropped;
    ogff_pkg::cell_t v;
    x = int'(r.x);
    y = int'(r.y);
    case (r.op)
      ogff_pkg::OP_WRITE: begin
        v       = (r.val > ogff_pkg::CELL_OCCUPIED) ? ogff_pkg::CELL_OCCUPIED : r.val;
        dropped = !on_grid(x, y);
        if (!dropped) grid_model[cell_idx(x, y)] = v;
        queue_result(make_result(0, 0, 1'b0, dropped, 1'b1));
      end
      ogff_pkg::OP_MARK: begin
        dropped = 1'b0;
        for (int dx = -1; dx <= 1; dx++) begin
          for (int dy = -1; dy <= 1; dy++) begin
            if (on_grid(x + dx, y + dy))
              grid_model[cell_idx(x + dx, y + dy)] = ogff_pkg::CELL_FREE;
            else dropped = 1'b1;
          end
        end
        queue_result(make_result(0, 0, 1'b0, dropped, 1'b1));
      end
      ogff_pkg::OP_SCAN: begin
        n  = 0;
        lo = (GRID_LO > ogff_pkg::COORD_LO) ? GRID_LO : ogff_pkg::COORD_LO;
        hi = (GRID_HI < ogff_pkg::COORD_HI) ? GRID_HI : ogff_pkg::COORD_HI;
        for (int row = lo; row <= hi; row++) begin
          if (is_frontier(x, row)) begin
            queue_result(make_result(x, row, 1'b1, 1'b0, 1'b0));
            n++;
          end
        end
        if (n == 0) queue_result(make_result(0, 0, 1'b0, 1'b0, 1'b1));
        else due_results[due_results.size()-1].last = 1'b1;
      end
      default: begin
        queue_result(make_result(0, 0, 1'b0, 1'b0, 1'b1));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic add_req(ogff_pkg::opcode_t op, int x, int y, int v);
    grid_req_t r;
    r.op  = op;
    r.x   = ogff_pkg::coord_t'(x);
    r.y   = ogff_pkg::coord_t'(y);
    r.val = ogff_pkg::cell_t'(v);
    pending_reqs = {pending_reqs, r};
  endtask

  function automatic int clamp_coord(int v);
    if (v < ogff_pkg::COORD_LO) return ogff_pkg::COORD_LO;
    if (v > ogff_pkg::COORD_HI) return ogff_pkg::COORD_HI;
    return v;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 31)) - 16;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : drive
    bit idle;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_request(held_req);
        accepted <= accepted + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        idle = !(accepted >= 120 && accepted < 200) && ($urandom_range(0, 99) < 7);
        if (pending_reqs.size() != 0 && !idle) begin
          held_req         = pending_reqs.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.opcode     <= held_req.op;
          in_ch.x_coord    <= held_req.x;
          in_ch.y_coord    <= held_req.y;
          in_ch.cell_value <= held_req.val;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : watch
    grid_result_t exp_r;
    grid_result_t got_r;
    bit           stall;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        got_r = make_result(int'(out_ch.found_x), int'(out_ch.found_y), out_ch.frontier_found,
                            out_ch.write_dropped, out_ch.last_result);
        if (due_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 40)
            $display("%0t unexpected result: expected none, actual x=%0d y=%0d f=%b d=%b l=%b",
                     $realtime, got_r.fx, got_r.fy, got_r.found, got_r.dropped, got_r.last);
        end else begin
          exp_r = due_results.pop_front();
          if (got_r.fx !== exp_r.fx || got_r.fy !== exp_r.fy || got_r.found !== exp_r.found ||
              got_r.dropped !== exp_r.dropped || got_r.last !== exp_r.last) begin
            fail_cnt++;
            if (fail_cnt <= 40)
              $display({"%0t mismatch: expected x=%0d y=%0d f=%b d=%b l=%b, ",
                        "actual x=%0d y=%0d f=%b d=%b l=%b"},
                       $realtime, exp_r.fx, exp_r.fy, exp_r.found, exp_r.dropped, exp_r.last,
                       got_r.fx, got_r.fy, got_r.found, got_r.dropped, got_r.last);
          end
        end
      end
      stall = !(results_seen >= 150 && results_seen < 260) && ($urandom_range(0, 99) < 7);
      out_ch.ready <= !(hold_left > 0) && !stall;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin : main
    int n_rand;
    int pick;
    int focus_x;
    int x;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = ogff_pkg::OP_NONE;
    in_ch.x_coord    = '0;
    in_ch.y_coord    = '0;
    in_ch.cell_value = '0;
    out_ch.ready     = 1'b0;
    rst_n            = 1'b0;
    accepted         = 0;
    results_seen     = 0;
    fail_cnt         = 0;
    foreach (grid_model[i]) grid_model[i] = ogff_pkg::CELL_UNKNOWN;

    // directed: empty grid, extremes, clipped marks, full and edge columns
    add_req(ogff_pkg::OP_SCAN, 0, 7, 0);
    add_req(ogff_pkg::OP_WRITE, -16, -16, 0);
    add_req(ogff_pkg::OP_WRITE, 15, 15, 3);
    add_req(ogff_pkg::OP_WRITE, 0, 0, 2);
    add_req(ogff_pkg::OP_NONE, -1, -1, 3);
    add_req(ogff_pkg::OP_MARK, -16, -16, 3);
    add_req(ogff_pkg::OP_MARK, 15, 15, 0);
    add_req(ogff_pkg::OP_MARK, 15, -16, 1);
    add_req(ogff_pkg::OP_MARK, 0, 0, 2);
    add_req(ogff_pkg::OP_MARK, 5, -3, 0);
    for (int yy = -15; yy <= 15; yy += 3) add_req(ogff_pkg::OP_MARK, -15, yy, 0);
    add_req(ogff_pkg::OP_SCAN, -16, -16, 3);
    add_req(ogff_pkg::OP_SCAN, -15, 15, 0);
    add_req(ogff_pkg::OP_SCAN, 15, 0, 0);
    add_req(ogff_pkg::OP_SCAN, 0, 0, 0);
    add_req(ogff_pkg::OP_SCAN, 5, -1, 0);

    // random: mostly marks and scans around a moving focus column
    n_rand  = 0;
    focus_x = 0;
    while (n_rand < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        add_req(ogff_pkg::OP_NONE, rand_coord(), rand_coord(), $urandom_range(0, 3));
      end else begin
        n_rand++;
        if (pick < 40) begin
          x = ($urandom_range(0, 9) < 6) ? clamp_coord(focus_x + $urandom_range(0, 4) - 2)
                                         : rand_coord();
          focus_x = x;
          add_req(ogff_pkg::OP_MARK, x, rand_coord(), $urandom_range(0, 3));
        end else if (pick < 62) begin
          add_req(ogff_pkg::OP_WRITE, rand_coord(), rand_coord(), $urandom_range(0, 3));
        end else begin
          x = ($urandom_range(0, 9) < 7) ? clamp_coord(focus_x + $urandom_range(0, 4) - 2)
                                         : rand_coord();
          add_req(ogff_pkg::OP_SCAN, x, rand_coord(), $urandom_range(0, 3));
        end
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_ch.valid || due_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
